[rtl/prim_mst_pkg.sv]
package prim_mst_pkg;

  // Graph size and field widths
  localparam int NODES    = 8;
  localparam int NODE_W   = 3;
  localparam int WEIGHT_W = 16;
  localparam int KEY_W    = WEIGHT_W + 1;
  localparam int IDX_W    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CNT_W    = $clog2(NODES + 1);
  localparam int ADDR_W   = $clog2(NODES * NODES);
  localparam int MEM_DEPTH = NODES * NODES;

  // Key value above every edge weight
  localparam logic [KEY_W-1:0] INF_KEY = KEY_W'(1) << WEIGHT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_DECIDE,
    ST_RELAX,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // store the accepted matrix entry
    logic init;      // reset keys, parents, visited flags and scan tracker
    logic scan_step; // examine one node for the least key
    logic commit;    // mark the picked node visited, start relaxing
    logic relax_step;// one matrix read / key update
    logic scan_clr;  // restart the least-key search
    logic emit_start;// point at the first child node
    logic emit_step; // load one result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_end;
    logic found;
    logic relax_end;
    logic emit_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

[rtl/prim_mst_if.sv]
interface prim_mst_in_if import prim_mst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [NODE_W-1:0]   row_node;
  logic [NODE_W-1:0]   col_node;
  logic [WEIGHT_W-1:0] edge_weight;
  logic                last_entry;

  modport source (output valid, row_node, col_node, edge_weight, last_entry, input ready);
  modport sink   (input valid, row_node, col_node, edge_weight, last_entry, output ready);
endinterface

interface prim_mst_out_if import prim_mst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [NODE_W-1:0]   child_node;
  logic [NODE_W-1:0]   parent_node;
  logic [WEIGHT_W-1:0] tree_weight;
  logic                reached;
  logic                last_edge;

  modport source (output valid, child_node, parent_node, tree_weight, reached, last_edge,
                  input ready);
  modport sink   (input valid, child_node, parent_node, tree_weight, reached, last_edge,
                  output ready);
endinterface

[rtl/prim_mst_ram.sv]
module prim_mst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/prim_mst_ctrl.sv]
module prim_mst_ctrl import prim_mst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  input  ctrl_sts_t  sts,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_last) state_nxt = ST_INIT;
      end
      ST_INIT:   state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sts.scan_end) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: state_nxt = sts.found ? ST_RELAX : ST_EMIT;
      ST_RELAX: begin
        if (sts.relax_end) state_nxt = ST_SCAN;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_INIT:   cmd.init = 1'b1;
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_DECIDE: begin
        cmd.commit     = sts.found;
        cmd.emit_start = !sts.found;
      end
      ST_RELAX: begin
        cmd.relax_step = 1'b1;
        cmd.scan_clr   = sts.relax_end;
      end
      ST_EMIT:   cmd.emit_step = sts.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/prim_mst_dp.sv]
module prim_mst_dp import prim_mst_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output ctrl_sts_t           sts,
  input  logic [NODE_W-1:0]   in_row,
  input  logic [NODE_W-1:0]   in_col,
  input  logic [WEIGHT_W-1:0] in_weight,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NODE_W-1:0]   out_child,
  output logic [NODE_W-1:0]   out_parent,
  output logic [WEIGHT_W-1:0] out_weight,
  output logic                out_reached,
  output logic                out_last
);

  logic [KEY_W-1:0]    key_r [NODES];
  logic [KEY_W-1:0]    key_nxt [NODES];
  logic [IDX_W-1:0]    par_r [NODES];
  logic [IDX_W-1:0]    par_nxt [NODES];
  logic [NODES-1:0]    vis_r, vis_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [KEY_W-1:0]    least_r, least_nxt;
  logic [IDX_W-1:0]    pick_r, pick_nxt;
  logic                found_r, found_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]   out_child_r, out_child_nxt;
  logic [NODE_W-1:0]   out_parent_r, out_parent_nxt;
  logic [WEIGHT_W-1:0] out_weight_r, out_weight_nxt;
  logic                out_reached_r, out_reached_nxt;
  logic                out_last_r, out_last_nxt;

  logic [IDX_W-1:0]    cur_idx;
  logic [CNT_W-1:0]    cnt_dec;
  logic [IDX_W-1:0]    upd_idx;
  logic                row_ok, col_ok;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [WEIGHT_W-1:0] mem_rdata;
  logic                emit_ok;

  assign cur_idx = cnt_r[IDX_W-1:0];
  assign cnt_dec = cnt_r - CNT_W'(1);
  assign upd_idx = cnt_dec[IDX_W-1:0];

  // Matrix store: entries written while loading, rows read while relaxing
  assign row_ok    = (32'(in_row) < NODES);
  assign col_ok    = (32'(in_col) < NODES);
  assign mem_we    = cmd.load && row_ok && col_ok;
  assign mem_waddr = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(NODES) + ADDR_W'(in_col));
  assign mem_raddr = ADDR_W'(ADDR_W'(pick_r) * ADDR_W'(NODES) + ADDR_W'(cur_idx));

  prim_mst_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MEM_DEPTH)
  ) u_adj_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_weight),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Status
  assign sts.scan_end  = (cnt_r == CNT_W'(NODES - 1));
  assign sts.found     = found_r;
  assign sts.relax_end = (cnt_r == CNT_W'(NODES));
  assign sts.emit_last = (cnt_r == CNT_W'(NODES - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  // Tree state: keys, parents, visited flags, search tracker
  always_comb begin
    key_nxt   = key_r;
    par_nxt   = par_r;
    vis_nxt   = vis_r;
    cnt_nxt   = cnt_r;
    least_nxt = least_r;
    pick_nxt  = pick_r;
    found_nxt = found_r;

    if (cmd.init) begin
      for (int i = 0; i < NODES; i++) begin
        key_nxt[i] = INF_KEY;
        par_nxt[i] = '0;
      end
      key_nxt[0] = '0;
      vis_nxt    = '0;
    end

    if (cmd.init || cmd.scan_clr) begin
      cnt_nxt   = '0;
      least_nxt = INF_KEY;
      pick_nxt  = '0;
      found_nxt = 1'b0;
    end

    // Least-key search, one node a cycle, ties to the lower index
    if (cmd.scan_step) begin
      if (!vis_r[cur_idx] && (key_r[cur_idx] < least_r)) begin
        least_nxt = key_r[cur_idx];
        pick_nxt  = cur_idx;
        found_nxt = 1'b1;
      end
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (cmd.commit) begin
      vis_nxt[pick_r] = 1'b1;
      cnt_nxt         = '0;
    end

    // Read issued for column cnt, update applied for column cnt-1
    if (cmd.relax_step) begin
      if (cnt_r != '0) begin
        if ((mem_rdata != '0) && !vis_r[upd_idx] &&
            ({1'b0, mem_rdata} < key_r[upd_idx])) begin
          key_nxt[upd_idx] = {1'b0, mem_rdata};
          par_nxt[upd_idx] = pick_r;
        end
      end
      if (!cmd.scan_clr) cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (cmd.emit_start) begin
      cnt_nxt = CNT_W'(1);
    end

    if (cmd.emit_step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // Result register
  assign emit_ok = vis_r[cur_idx] && (key_r[cur_idx] < INF_KEY);

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_child_nxt   = out_child_r;
    out_parent_nxt  = out_parent_r;
    out_weight_nxt  = out_weight_r;
    out_reached_nxt = out_reached_r;
    out_last_nxt    = out_last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit_step) begin
      out_valid_nxt   = 1'b1;
      out_child_nxt   = NODE_W'(cnt_r);
      out_parent_nxt  = emit_ok ? NODE_W'(par_r[cur_idx]) : '0;
      out_weight_nxt  = emit_ok ? key_r[cur_idx][WEIGHT_W-1:0] : '0;
      out_reached_nxt = emit_ok;
      out_last_nxt    = sts.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r       <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vis_r       <= vis_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    par_r         <= par_nxt;
    least_r       <= least_nxt;
    pick_r        <= pick_nxt;
    out_child_r   <= out_child_nxt;
    out_parent_r  <= out_parent_nxt;
    out_weight_r  <= out_weight_nxt;
    out_reached_r <= out_reached_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_child   = out_child_r;
  assign out_parent  = out_parent_r;
  assign out_weight  = out_weight_r;
  assign out_reached = out_reached_r;
  assign out_last    = out_last_r;

endmodule

[rtl/prim_minimum_spanning_tree_unit.sv]
// Channel   Dir  Handshake       Payload
// in_ch     in   valid / ready   row_node, col_node, edge_weight, last_entry
// out_ch    out  valid / ready   child_node, parent_node, tree_weight, reached, last_edge
//
// Matrix entries are taken one per cycle while the unit is idle.
// An entry with last_entry set starts a run: a setup step, then per picked node a
// least-key search over all nodes, a decide step and row reads from the registered-read
// matrix RAM; a final search that finds no unvisited node with a finite key ends the run.
// Results then leave one per cycle (NODES-1 of them), each waiting while out_ch stalls.
// Reset (rst_n low, synchronous) returns to idle; the matrix contents are kept.
module prim_minimum_spanning_tree_unit import prim_mst_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  prim_mst_in_if.sink     in_ch,
  prim_mst_out_if.source  out_ch
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_rdy;

  assign in_ch.ready = in_rdy;

  // Sequencer
  prim_mst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_entry),
    .in_ready (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Matrix, keys and result register
  prim_mst_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_row      (in_ch.row_node),
    .in_col      (in_ch.col_node),
    .in_weight   (in_ch.edge_weight),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_child   (out_ch.child_node),
    .out_parent  (out_ch.parent_node),
    .out_weight  (out_ch.tree_weight),
    .out_reached (out_ch.reached),
    .out_last    (out_ch.last_edge)
  );

endmodule

[tb/sv/prim_mst_checker.sv]
module prim_mst_checker import prim_mst_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  prim_mst_in_if  in_mon,
  prim_mst_out_if out_mon,
  output int      mismatches,
  output int      pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // One spanning tree edge as the block reports it
  typedef struct packed {
    logic [NODE_W-1:0]   child;
    logic [NODE_W-1:0]   parent;
    logic [WEIGHT_W-1:0] weight;
    logic                reached;
    logic                last;
  } tree_edge_t;

  logic [WEIGHT_W-1:0] adj_matrix [MEM_DEPTH];
  tree_edge_t          expected_edges [$];

  // Prim from node 0 over the stored matrix, row by row; queues one edge per node 1..NODES-1
  function automatic void predict_tree();
    logic [KEY_W-1:0]  key [NODES];
    logic [IDX_W-1:0]  parent [NODES];
    logic              visited [NODES];
    logic [KEY_W-1:0]  least;
    logic [KEY_W-1:0]  w;
    int                pick;
    bit                found;
    bit                ok;
    tree_edge_t        e;
    for (int i = 0; i < NODES; i++) begin
      key[i]     = INF_KEY;
      parent[i]  = '0;
      visited[i] = 1'b0;
    end
    key[0] = '0;
    for (int round = 0; round < NODES; round++) begin
      least = INF_KEY;
      pick  = 0;
      found = 1'b0;
      // least key, ties to the lowest index
      for (int v = 0; v < NODES; v++) begin
        if (!visited[v] && key[v] < least) begin
          least = key[v];
          pick  = v;
          found = 1'b1;
        end
      end
      if (!found) break;
      visited[pick] = 1'b1;
      for (int v = 0; v < NODES; v++) begin
        w = KEY_W'(adj_matrix[pick * NODES + v]);
        if (w != '0 && !visited[v] && w < key[v]) begin
          key[v]    = w;
          parent[v] = IDX_W'(pick);
        end
      end
    end
    for (int i = 1; i < NODES; i++) begin
      ok        = visited[i] && (key[i] < INF_KEY);
      e.child   = NODE_W'(i);
      e.parent  = ok ? NODE_W'(parent[i]) : '0;
      e.weight  = ok ? key[i][WEIGHT_W-1:0] : '0;
      e.reached = ok;
      e.last    = (i == NODES - 1);
      expected_edges.push_back(e);
    end
  endfunction

  // One line per bad field
  task automatic report_error(input string what, input int node, input logic [31:0] got,
                              input logic [31:0] want);
    $display("%0t ns: edge to node %0d, %s = %0d, predicted %0d", $time, node, what, got,
             want);
    mismatches++;
  endtask

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    tree_edge_t got;
    tree_edge_t want;
    if (rst_n) begin
      // matrix entry transaction: store, then run on the last one
      if (in_mon.valid && in_mon.ready) begin
        if (int'(in_mon.row_node) < NODES && int'(in_mon.col_node) < NODES) begin
          adj_matrix[int'(in_mon.row_node) * NODES + int'(in_mon.col_node)] = in_mon.edge_weight;
        end
        if (in_mon.last_entry) predict_tree();
      end
      // tree edge transaction
      if (out_mon.valid && out_mon.ready) begin
        got.child   = out_mon.child_node;
        got.parent  = out_mon.parent_node;
        got.weight  = out_mon.tree_weight;
        got.reached = out_mon.reached;
        got.last    = out_mon.last_edge;
        if (expected_edges.size() == 0) begin
          report_error("unexpected result, child", int'(got.child), 32'(got.child), '0);
        end else begin
          want = expected_edges.pop_front();
          if (got.child !== want.child)
            report_error("child_node", int'(want.child), 32'(got.child), 32'(want.child));
          if (got.parent !== want.parent)
            report_error("parent_node", int'(want.child), 32'(got.parent),
                         32'(want.parent));
          if (got.weight !== want.weight)
            report_error("tree_weight", int'(want.child), 32'(got.weight),
                         32'(want.weight));
          if (got.reached !== want.reached)
            report_error("reached", int'(want.child), 32'(got.reached), 32'(want.reached));
          if (got.last !== want.last)
            report_error("last_edge", int'(want.child), 32'(got.last), 32'(want.last));
        end
      end
    end
    pending_results = expected_edges.size();
  end

endmodule

[tb/sv/tb_top.sv]
module tb_top import prim_mst_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 300;

  typedef struct packed {
    logic [NODE_W-1:0]   row;
    logic [NODE_W-1:0]   col;
    logic [WEIGHT_W-1:0] weight;
  } matrix_entry_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic rx_ready = 1'b0;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int items_sent   = 0;
  int cycle_count  = 0;
  int fail_count;
  int pending_results;

  matrix_entry_t entry_batch [$];

  prim_mst_in_if  in_ch ();
  prim_mst_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  prim_minimum_spanning_tree_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  prim_mst_checker tree_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatches      (fail_count),
    .pending_results (pending_results)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure
  always @(negedge clk) begin
    rx_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("prim_minimum_spanning_tree_unit: mismatch");
      $finish;
    end
  end

  // Weight mix: no edge, max, small values for ties, anything
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) return '0;
    if (sel < 30) return '1;
    if (sel < 50) return WEIGHT_W'($urandom_range(1, 4));
    return WEIGHT_W'($urandom);
  endfunction

  function automatic void add_entry(input logic [NODE_W-1:0] r, input logic [NODE_W-1:0] c,
                                    input logic [WEIGHT_W-1:0] w);
    matrix_entry_t e;
    e.row    = r;
    e.col    = c;
    e.weight = w;
    entry_batch.push_back(e);
  endfunction

  // Drive one entry transaction; called and returns at a falling edge
  task automatic push_entry(input matrix_entry_t e, input logic last);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.row_node    <= e.row;
    in_ch.col_node    <= e.col;
    in_ch.edge_weight <= e.weight;
    in_ch.last_entry  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send the batch; its final entry starts the run
  task automatic flush_batch();
    for (int i = 0; i < entry_batch.size(); i++) begin
      push_entry(entry_batch[i], i == entry_batch.size() - 1);
      items_sent++;
    end
    entry_batch.delete();
  endtask

  // Random edits: mostly mirrored edges, some one-sided, now and then a node cut off
  task automatic random_run();
    logic [NODE_W-1:0]   a;
    logic [NODE_W-1:0]   b;
    logic [WEIGHT_W-1:0] w;
    int                  n_pairs;
    if ($urandom_range(99) < 8) begin
      a = NODE_W'($urandom_range(NODES - 1));
      for (int v = 0; v < NODES; v++) begin
        add_entry(a, NODE_W'(v), '0);
        add_entry(NODE_W'(v), a, '0);
      end
    end
    n_pairs = $urandom_range(1, 4);
    repeat (n_pairs) begin
      a = NODE_W'($urandom_range(NODES - 1));
      b = NODE_W'($urandom_range(NODES - 1));
      w = pick_weight();
      add_entry(a, b, w);
      if ($urandom_range(99) < 85) add_entry(b, a, w);
    end
    flush_batch();
  endtask

  // Stimulus
  initial begin
    int phase_tx [4];
    int phase_rx [4];
    phase_tx = '{0, 47, 0, 32};
    phase_rx = '{0, 0, 47, 32};
    in_ch.valid       = 1'b0;
    in_ch.row_node    = '0;
    in_ch.col_node    = '0;
    in_ch.edge_weight = '0;
    in_ch.last_entry  = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // clear the whole matrix; first run sees no edges at all
    for (int r = 0; r < NODES; r++) begin
      for (int c = 0; c < NODES; c++) add_entry(NODE_W'(r), NODE_W'(c), '0);
    end
    flush_batch();
    // heaviest edge
    add_entry(3'd0, 3'd1, '1);
    add_entry(3'd1, 3'd0, '1);
    flush_batch();
    // lighter path replaces the direct edge
    add_entry(3'd0, 3'd2, 16'd1);
    add_entry(3'd2, 3'd0, 16'd1);
    add_entry(3'd1, 3'd2, 16'd7);
    add_entry(3'd2, 3'd1, 16'd7);
    flush_batch();
    // equal keys, lowest index first
    add_entry(3'd0, 3'd3, 16'd7);
    add_entry(3'd3, 3'd0, 16'd7);
    add_entry(3'd2, 3'd3, 16'd7);
    add_entry(3'd3, 3'd2, 16'd7);
    flush_batch();
    // one-sided edge into the tree does not reach node 4
    add_entry(3'd4, 3'd0, 16'd9);
    flush_batch();
    // self loop and a separate component
    add_entry(3'd5, 3'd5, 16'd3);
    add_entry(3'd6, 3'd7, 16'd2);
    add_entry(3'd7, 3'd6, 16'd2);
    flush_batch();
    // join the separate component
    add_entry(3'd0, 3'd7, 16'hfffe);
    add_entry(3'd7, 3'd0, 16'hfffe);
    flush_batch();

    // random runs under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = phase_tx[ph];
      rx_stall_pct = phase_rx[ph];
      while (items_sent < 80 + (ph + 1) * 48) random_run();
    end
    in_ch.valid <= 1'b0;

    while (pending_results != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("prim_minimum_spanning_tree_unit: match");
    end else begin
      $display("prim_minimum_spanning_tree_unit: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/prim_mst_pkg.sv
rtl/prim_mst_if.sv
rtl/prim_mst_ram.sv
rtl/prim_mst_ctrl.sv
rtl/prim_mst_dp.sv
rtl/prim_minimum_spanning_tree_unit.sv
tb/sv/prim_mst_checker.sv
tb/sv/tb_top.sv
